// ===== hdl/mft_pkg.sv =====
// Package: shared constants, codes, command/status types and helpers for the monobit test.
`default_nettype none
package mft_pkg;

	localparam int COUNT_WIDTH_DEF = 28;
	localparam int OUT_CNT_W       = 28;
	localparam int STAT_W          = 44;
	localparam int THR_W           = 24;
	localparam int MINB_W          = 8;
	localparam int FRAC_BITS       = 16;
	localparam int CFG_DATA_W      = 24;
	localparam int CFG_IDX_W       = 1;

	localparam logic [THR_W-1:0]  THR_RESET  = 24'd251757;
	localparam logic [MINB_W-1:0] MINB_RESET = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_PASS_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BITS       = 1'd1;

	typedef enum logic [1:0] {
		VERDICT_PASS  = 2'd0,
		VERDICT_FAIL  = 2'd1,
		VERDICT_SHORT = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		ST_COUNT,
		ST_SETUP,
		ST_SQUARE,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic count;
		logic setup;
		logic sq_step;
		logic div_start;
		logic div_step;
		logic load_out;
	} mft_cmd_t;

	typedef struct packed {
		logic skip;
		logic sq_done;
		logic div_done;
	} mft_sts_t;

	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, b[i]};
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mft_in_if.sv =====
// Interface: input byte channel with valid/ready handshake.
`default_nettype none
interface mft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== hdl/mft_out_if.sv =====
// Interface: result channel with valid/ready handshake.
`default_nettype none
interface mft_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [27:0] total_bits;
	logic [27:0] zero_total;
	logic [27:0] one_total;
	logic [43:0] statistic_q16;

	modport source (output valid, output verdict, output total_bits, output zero_total,
		output one_total, output statistic_q16, input ready);
	modport sink (input valid, input verdict, input total_bits, input zero_total,
		input one_total, input statistic_q16, output ready);
endinterface
`default_nettype wire

// ===== hdl/monobit_frequency_test_top.sv =====
// Top level: monobit frequency test, controller plus datapath.
//
// Usage:
//   in_ch carries one byte of the tested stream per transaction, with
//   end_of_stream marking the final byte. Bytes that are not last are counted
//   at one per cycle and produce nothing. The last byte is counted too, and
//   then the block computes (zeros-ones)^2 * 2^16 / total_bits and emits one
//   transaction on out_ch with the verdict, the three counts and the statistic.
//   From the last byte to the result the block passes through a setup
//   state, shift-add squaring, restoring division and the load of the
//   result register. A short stream (total below min_bits) or an empty one
//   skips the arithmetic and goes from setup straight to the load.
//   in_ch.ready is low from the last byte until the result is loaded, so one
//   stream is evaluated at a time; the next stream's bytes are taken while a
//   result still waits in the output register.
//   If out_ch stalls with a result pending, the next result holds in the
//   datapath and in_ch stays stalled until the receiver takes the old one.
//   Reset clears the counters and the output valid and restores the
//   threshold (about 3.8415) and min_bits (10). Write config only when idle.
`default_nettype none
module monobit_frequency_test_top
	import mft_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mft_in_if.sink                     in_ch,
	mft_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	mft_cmd_t cmd;
	mft_sts_t sts;

	// sequence the phases of one stream
	mft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_eos    (in_ch.end_of_stream),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counting, arithmetic and the result register
	mft_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (in_ch.data_byte),
		.cmd           (cmd),
		.sts           (sts),
		.verdict       (out_ch.verdict),
		.total_bits    (out_ch.total_bits),
		.zero_total    (out_ch.zero_total),
		.one_total     (out_ch.one_total),
		.statistic_q16 (out_ch.statistic_q16)
	);

endmodule
`default_nettype wire

// ===== hdl/mft_ctrl.sv =====
// Controller: sequences counting, squaring, division and result delivery.
`default_nettype none
module mft_ctrl
	import mft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_eos,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire mft_sts_t sts,
	output mft_cmd_t      cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_COUNT: begin
				if (in_valid && in_eos) state_nxt = ST_SETUP;
			end
			ST_SETUP: begin
				state_nxt = sts.skip ? ST_DELIVER : ST_SQUARE;
			end
			ST_SQUARE: begin
				if (sts.sq_done) state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_done) state_nxt = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (out_free) state_nxt = ST_COUNT;
			end
			default: state_nxt = ST_COUNT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_COUNT: begin
				in_ready  = 1'b1;
				cmd.count = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_SQUARE: begin
				cmd.sq_step   = !sts.sq_done;
				cmd.div_start = sts.sq_done;
			end
			ST_DIVIDE: cmd.div_step = !sts.div_done;
			ST_DELIVER: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COUNT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/mft_dp.sv =====
// Datapath: bit counters, shift-add squarer, restoring divider, config and result registers.
`default_nettype none
module mft_dp
	import mft_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]            data_byte,
	input  wire mft_cmd_t              cmd,
	output mft_sts_t                   sts,
	output logic [1:0]                 verdict,
	output logic [OUT_CNT_W-1:0]       total_bits,
	output logic [OUT_CNT_W-1:0]       zero_total,
	output logic [OUT_CNT_W-1:0]       one_total,
	output logic [STAT_W-1:0]          statistic_q16
);

	localparam int CW    = COUNT_WIDTH;
	localparam int PW    = 2 * CW;
	localparam int DW    = PW + FRAC_BITS;
	localparam int STEPW = $clog2(DW + 1);
	localparam int XW    = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	logic [THR_W-1:0]  thr_q;
	logic [MINB_W-1:0] minb_q;
	logic [CW-1:0]     zeros_q, ones_q;
	logic [CW-1:0]     den_q;
	logic              small_q;
	logic [PW-1:0]     mcand_q, prod_q;
	logic [CW-1:0]     mplier_q;
	logic [DW-1:0]     dvd_q;
	logic [CW-1:0]     rem_q;
	logic [STAT_W-1:0] quo_q;
	logic              sat_q;
	logic [STEPW-1:0]  step_q;

	logic [3:0]        pop_ones;
	logic [CW:0]       ones_sum, zeros_sum, total_sum;
	logic [CW-1:0]     ones_nxt, zeros_nxt, total_c, diff_c;
	logic              small_c;
	logic [CW:0]       rs, rdiff;
	logic              ge;
	logic [STAT_W-1:0] stat_c;

	function automatic logic [OUT_CNT_W-1:0] clip_out(input logic [CW-1:0] v);
		logic [XW-1:0] ext;
		ext = XW'(v);
		return (ext > XW'({OUT_CNT_W{1'b1}})) ? '1 : ext[OUT_CNT_W-1:0];
	endfunction

	assign pop_ones  = popcount8(data_byte);
	assign ones_sum  = {1'b0, ones_q} + (CW + 1)'(pop_ones);
	assign zeros_sum = {1'b0, zeros_q} + (CW + 1)'(4'd8 - pop_ones);
	assign ones_nxt  = ones_sum[CW] ? CNT_MAX : ones_sum[CW-1:0];
	assign zeros_nxt = zeros_sum[CW] ? CNT_MAX : zeros_sum[CW-1:0];

	assign total_sum = {1'b0, zeros_q} + {1'b0, ones_q};
	assign total_c   = total_sum[CW] ? CNT_MAX : total_sum[CW-1:0];
	assign diff_c    = (zeros_q >= ones_q) ? (zeros_q - ones_q) : (ones_q - zeros_q);
	assign small_c   = total_c < CW'(minb_q);

	assign sts.skip     = small_c || (total_c == '0);
	assign sts.sq_done  = (step_q == '0);
	assign sts.div_done = (step_q == '0);

	assign rs    = {rem_q, dvd_q[DW-1]};
	assign rdiff = rs - {1'b0, den_q};
	assign ge    = (rs >= {1'b0, den_q});

	assign stat_c = sat_q ? '1 : quo_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			minb_q <= MINB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PASS_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_MIN_BITS:       minb_q <= cfg_data[MINB_W-1:0];
				default: ;
			endcase
		end
	end

	// running bit counters; clear once the result is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zeros_q <= '0;
			ones_q  <= '0;
		end else if (cmd.load_out) begin
			zeros_q <= '0;
			ones_q  <= '0;
		end else if (cmd.count) begin
			zeros_q <= zeros_nxt;
			ones_q  <= ones_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.setup) begin
			step_q <= STEPW'(CW);
		end else if (cmd.div_start) begin
			step_q <= STEPW'(DW);
		end else if (cmd.sq_step || cmd.div_step) begin
			step_q <= step_q - 1'b1;
		end
	end

	// squarer and divider
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			den_q    <= total_c;
			small_q  <= small_c;
			mcand_q  <= PW'(diff_c);
			mplier_q <= diff_c;
			prod_q   <= '0;
			quo_q    <= '0;
			sat_q    <= 1'b0;
		end
		if (cmd.sq_step) begin
			if (mplier_q[0]) prod_q <= prod_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.div_start) begin
			dvd_q <= {prod_q, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rdiff[CW-1:0] : rs[CW-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[STAT_W-2:0], ge};
			sat_q <= sat_q | quo_q[STAT_W-1];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			total_bits <= clip_out(den_q);
			zero_total <= clip_out(zeros_q);
			one_total  <= clip_out(ones_q);
			if (small_q) begin
				verdict       <= VERDICT_SHORT;
				statistic_q16 <= '0;
			end else begin
				verdict       <= (stat_c <= STAT_W'(thr_q)) ? VERDICT_PASS : VERDICT_FAIL;
				statistic_q16 <= stat_c;
			end
		end
	end

endmodule
`default_nettype wire

// ===== test/monobit_frequency_test_top_tb.sv =====
// Testbench for monobit_frequency_test_top: random byte streams checked against a bit-level predictor.
`timescale 1ns / 100ps

module monobit_frequency_test_top_tb
	import mft_pkg::*;
();

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 6;
	// Drain after the last result, long enough for setup, squaring, division and load.
	localparam int DRAIN_CYCLES   = 150;
	// Receiver hold-off that backs the block up into its input.
	localparam int HOLD_CYCLES    = 600;
	// Longest correct stretch without a transaction: hold-off plus one evaluation plus a
	// drain and a settings write. Allow several times that.
	localparam int WATCHDOG_LIMIT = 5000;

	// One result transaction as seen on out_ch.
	typedef struct packed {
		verdict_t              verdict;
		logic [OUT_CNT_W-1:0]  total_bits;
		logic [OUT_CNT_W-1:0]  zero_total;
		logic [OUT_CNT_W-1:0]  one_total;
		logic [STAT_W-1:0]     statistic_q16;
	} stream_result_t;

	// Content style of one generated stream.
	typedef enum int {
		FLAVOR_UNIFORM,
		FLAVOR_ONES_HEAVY,
		FLAVOR_ZEROS_HEAVY,
		FLAVOR_CONSTANT,
		FLAVOR_BALANCED
	} byte_flavor_t;

	// Running bit tally of the current stream plus the verdicts still owed by the block.
	class monobit_tally;
		localparam logic [63:0] CNT_LIMIT  = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
		localparam logic [63:0] OUT_LIMIT  = (64'd1 << OUT_CNT_W) - 64'd1;
		localparam logic [63:0] STAT_LIMIT = (64'd1 << STAT_W) - 64'd1;

		logic [THR_W-1:0]  threshold;
		logic [MINB_W-1:0] min_bits;
		logic [63:0]       zeros_seen;
		logic [63:0]       ones_seen;
		stream_result_t    expected_verdicts[$];
		int                results_seen;
		int                mismatches;

		function new();
			threshold    = THR_RESET;
			min_bits     = MINB_RESET;
			zeros_seen   = 64'd0;
			ones_seen    = 64'd0;
			results_seen = 0;
			mismatches   = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_PASS_THRESHOLD) begin
				threshold = value[THR_W-1:0];
			end else if (idx == REG_MIN_BITS) begin
				min_bits = value[MINB_W-1:0];
			end
		endfunction

		function logic [63:0] sat_count(logic [63:0] a, logic [63:0] b);
			logic [63:0] s;
			s = a + b;
			return (s > CNT_LIMIT) ? CNT_LIMIT : s;
		endfunction

		function logic [OUT_CNT_W-1:0] clip_count(logic [63:0] v);
			return (v > OUT_LIMIT) ? OUT_LIMIT[OUT_CNT_W-1:0] : v[OUT_CNT_W-1:0];
		endfunction

		// floor(diff^2 * 2^16 / total), saturated to the statistic width
		function logic [STAT_W-1:0] scaled_statistic(logic [63:0] diff, logic [63:0] total);
			logic [127:0] num;
			logic [127:0] quo;
			num = (128'(diff) * 128'(diff)) << FRAC_BITS;
			quo = num / 128'(total);
			return (quo > 128'(STAT_LIMIT)) ? STAT_LIMIT[STAT_W-1:0] : quo[STAT_W-1:0];
		endfunction

		// Count one accepted byte; on the last byte of a stream, queue its verdict.
		function void count_byte(logic [7:0] b, logic last);
			logic [63:0]    n_ones;
			logic [63:0]    total;
			logic [63:0]    diff;
			stream_result_t res;
			n_ones     = 64'($countones(b));
			ones_seen  = sat_count(ones_seen, n_ones);
			zeros_seen = sat_count(zeros_seen, 64'd8 - n_ones);
			if (!last) begin
				return;
			end
			total = sat_count(zeros_seen, ones_seen);
			res.statistic_q16 = '0;
			if (total < 64'(min_bits)) begin
				res.verdict = VERDICT_SHORT;
			end else begin
				diff = (zeros_seen >= ones_seen) ? zeros_seen - ones_seen : ones_seen - zeros_seen;
				if (total != 64'd0) begin
					res.statistic_q16 = scaled_statistic(diff, total);
				end
				res.verdict = (64'(res.statistic_q16) <= 64'(threshold)) ? VERDICT_PASS
				                                                         : VERDICT_FAIL;
			end
			res.total_bits = clip_count(total);
			res.zero_total = clip_count(zeros_seen);
			res.one_total  = clip_count(ones_seen);
			expected_verdicts.push_back(res);
			zeros_seen = 64'd0;
			ones_seen  = 64'd0;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: result %0d: %s", $time, results_seen, msg);
			mismatches++;
		endtask

		task compare_result(stream_result_t got);
			stream_result_t want;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result arrived with no stream pending");
				results_seen++;
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.verdict != want.verdict)
				report_mismatch($sformatf("verdict %0d, expected %0d",
					got.verdict, want.verdict));
			if (got.total_bits != want.total_bits)
				report_mismatch($sformatf("total_bits %0d, expected %0d",
					got.total_bits, want.total_bits));
			if (got.zero_total != want.zero_total)
				report_mismatch($sformatf("zero_total %0d, expected %0d",
					got.zero_total, want.zero_total));
			if (got.one_total != want.one_total)
				report_mismatch($sformatf("one_total %0d, expected %0d",
					got.one_total, want.one_total));
			if (got.statistic_q16 != want.statistic_q16)
				report_mismatch($sformatf("statistic_q16 %0d, expected %0d",
					got.statistic_q16, want.statistic_q16));
			results_seen++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mft_in_if  in_ch();
	mft_out_if out_ch();

	monobit_frequency_test_top #(
		.COUNT_WIDTH(COUNT_WIDTH_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	monobit_tally tally;

	// Sender pacing: bytes left in the current burst, and a switch that turns gaps off.
	int burst_left    = 0;
	bit steady_sender = 1'b0;
	// Raised by the main flow; the receiver picks it up and holds off on its own count.
	bit hold_request  = 1'b0;
	int idle_cycles   = 0;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Watchdog: count cycles in which no transaction and no register write takes place.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("monobit_frequency_test_top test failed");
			$finish;
		end
	end

	// Receiver: check every accepted result, then pick ready for the next edge.
	// The stall pattern is redrawn at random whenever its mode count runs out, among always
	// ready, coin toss, one edge in four and a fixed 2-of-5 low duty.
	initial begin
		int             stall_mode;
		int             mode_left;
		int             phase_cnt;
		int             hold_left;
		stream_result_t got;
		stall_mode = 0;
		mode_left  = 0;
		phase_cnt  = 0;
		hold_left  = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.verdict       = verdict_t'(out_ch.verdict);
				got.total_bits    = out_ch.total_bits;
				got.zero_total    = out_ch.zero_total;
				got.one_total     = out_ch.one_total;
				got.statistic_q16 = out_ch.statistic_q16;
				tally.compare_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = 50;
			end
			mode_left--;
			phase_cnt++;
			if (hold_left > 0) begin
				// Hold off the result so the next stream backs up into in_ch.
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: begin
						out_ch.ready <= 1'b1;
					end
					1: begin
						out_ch.ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						out_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ch.ready <= ((phase_cnt % 5) >= 2);
					end
				endcase
			end
		end
	end

	// Offer one byte and hold it until the block takes it; then maybe drop valid for a gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= b;
		in_ch.end_of_stream <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		tally.count_byte(b, last);
		if (steady_sender) begin
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// Drop valid if the last byte left it high.
	task automatic quiet_sender();
		if (in_ch.valid) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Wait until every owed result is in, then let the block run idle.
	task automatic settle();
		while (tally.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back, with the enable held across the pair.
	task automatic apply_settings(input logic [THR_W-1:0] thr, input logic [MINB_W-1:0] minb);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PASS_THRESHOLD;
		cfg_data  <= CFG_DATA_W'(thr);
		@(posedge clk);
		tally.set_register(REG_PASS_THRESHOLD, CFG_DATA_W'(thr));
		cfg_index <= REG_MIN_BITS;
		cfg_data  <= CFG_DATA_W'(minb);
		@(posedge clk);
		tally.set_register(REG_MIN_BITS, CFG_DATA_W'(minb));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] stream_byte(byte_flavor_t flavor, logic [7:0] prev, int pos);
		case (flavor)
			FLAVOR_ONES_HEAVY:  return 8'($urandom) | 8'($urandom);
			FLAVOR_ZEROS_HEAVY: return 8'($urandom) & 8'($urandom);
			FLAVOR_CONSTANT: begin
				if (pos == 0)
					return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
				return prev;
			end
			FLAVOR_BALANCED: begin
				if (pos % 2 == 1)
					return ~prev;
				return 8'($urandom);
			end
			default:            return 8'($urandom);
		endcase
	endfunction

	// Send one whole stream of len bytes, the last one marked end_of_stream.
	task automatic send_stream(input int len);
		byte_flavor_t flavor;
		logic [7:0]   b;
		int           k;
		flavor = byte_flavor_t'($urandom_range(0, 4));
		b      = 8'h00;
		for (k = 0; k < len; k++) begin
			b = stream_byte(flavor, b, k);
			send_byte(b, k == len - 1);
		end
	endtask

	// One random phase: settle, write the settings, then send whole streams of mixed length.
	// Most streams are short so results come often; a tail of long ones clears large min_bits.
	task automatic run_phase(input logic [THR_W-1:0] thr, input logic [MINB_W-1:0] minb,
		input int n_items, input bit hold, input bit steady);
		int sent;
		int len;
		int r;
		settle();
		apply_settings(thr, minb);
		steady_sender = steady;
		if (hold) begin
			hold_request = 1'b1;
		end
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = $urandom_range(1, 10);
			else if (r < 90)
				len = $urandom_range(11, 40);
			else
				len = $urandom_range(41, 96);
			send_stream(len);
			sent += len;
		end
		quiet_sender();
		steady_sender = 1'b0;
	endtask

	initial begin
		tally = new();
		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.data_byte     <= 8'h00;
		in_ch.end_of_stream <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_PASS_THRESHOLD;
		cfg_data            <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: single all-zero and all-one bytes fall short of min_bits,
		// a balanced pair passes, a run of ones fails.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		quiet_sender();

		// Threshold exactly equal to the statistic of FF 00 FF (64 * 2^16 / 24, truncated)
		// must pass; a total equal to min_bits is evaluated; one below is short.
		settle();
		apply_settings(24'd174762, 8'd16);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'h0F, 1'b1);
		quiet_sender();

		// One below that statistic fails; min_bits of zero lets a single byte through.
		settle();
		apply_settings(24'd174761, 8'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		quiet_sender();

		// Random phases over a spread of settings, the extremes among them.
		run_phase(24'd0, 8'd0, 80, 1'b0, 1'b0);
		run_phase(24'hFFFFFF, 8'd255, 100, 1'b0, 1'b0);
		run_phase(THR_RESET, MINB_RESET, 130, 1'b1, 1'b0);
		run_phase(THR_W'($urandom_range(0, 400000)), MINB_W'($urandom_range(0, 64)),
			100, 1'b0, 1'b0);
		run_phase(THR_W'($urandom), MINB_W'($urandom), 80, 1'b0, 1'b0);
		run_phase(24'd65536, 8'd8, 110, 1'b0, 1'b1);
		run_phase(THR_RESET, MINB_RESET, 100, 1'b0, 1'b0);

		// Drain: every owed result in, then idle long enough to catch a stray one.
		while (tally.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tally.mismatches == 0) begin
			$display("monobit_frequency_test_top test passed");
		end else begin
			$display("monobit_frequency_test_top test failed");
		end
		$finish;
	end

endmodule

// ===== monobit_frequency_test_top.f =====
hdl/mft_pkg.sv
hdl/mft_in_if.sv
hdl/mft_out_if.sv
hdl/mft_ctrl.sv
hdl/mft_dp.sv
hdl/monobit_frequency_test_top.sv
test/monobit_frequency_test_top_tb.sv
